FILE: rtl/core/fict_pkg.sv
// ----------------------------------------------------------------------------
// fict_pkg: shared types and constants of the catch-up timer
// Field widths, register index codes, reset values and the add/sub unit's
// request and response records.
// ----------------------------------------------------------------------------
package fict_pkg;

    localparam int TIME_W  = 63;
    localparam int ALU_W   = 64;
    localparam int IVL_W   = 32;
    localparam int RUN_W   = 8;
    localparam int BKL_W   = 16;
    localparam int SPAN_W  = IVL_W + BKL_W;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CIDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_INTERVAL    = 2'd0;
    localparam cfg_idx_t REG_MAX_RUN     = 2'd1;
    localparam cfg_idx_t REG_LIMIT_BKL   = 2'd2;
    localparam cfg_idx_t REG_MAX_BKL     = 2'd3;

    localparam logic [IVL_W-1:0] INTERVAL_RST = 32'd16666;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             borrow;
    } alu_rsp_t;

endpackage

FILE: rtl/core/fict_ifs.sv
// ----------------------------------------------------------------------------
// fict_ifs: request channels of the catch-up timer
// Check channel (current time in) and result channel (fire flag, next due).
// ----------------------------------------------------------------------------
interface fict_check_if;
    import fict_pkg::*;

    logic  valid;
    logic  ready;
    time_t now_us;

    modport source (output valid, output now_us, input ready);
    modport sink (input valid, input now_us, output ready);
endinterface

interface fict_result_if;
    import fict_pkg::*;

    logic  valid;
    logic  ready;
    logic  fire;
    time_t next_due_us;

    modport source (output valid, output fire, output next_due_us, input ready);
    modport sink (input valid, input fire, input next_due_us, output ready);
endinterface

FILE: rtl/core/fict_alu.sv
// ----------------------------------------------------------------------------
// fict_alu: shared 64-bit adder/subtractor
// Adds or subtracts two operands; flags a borrow when a < b on subtract.
// ----------------------------------------------------------------------------
module fict_alu (
    input  fict_pkg::alu_req_t req,
    output fict_pkg::alu_rsp_t rsp
);
    import fict_pkg::*;

    logic [ALU_W:0]   total;
    logic [ALU_W-1:0] b_op;

    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.sum    = total[ALU_W-1:0];
    assign rsp.borrow = req.sub & ~total[ALU_W];
endmodule

FILE: rtl/core/fixed_interval_catchup_timer_unit.sv
// ----------------------------------------------------------------------------
// fixed_interval_catchup_timer_unit: fixed-interval catch-up timer
// Due-check sequencer around one shared add/sub unit.
// ----------------------------------------------------------------------------
// Usage:
//   check  : one request per due-check, carrying now_us (microseconds).
//   result : one request per check: fire and next_due_us.
//   cfg    : cfg_we/cfg_index/cfg_data write interval_us, max_run,
//            limit_backlog and max_backlog; write only while idle.
// Steps (accept to result valid), all on the one add/sub unit:
//   forced rest            : next due from now, output
//   no backlog limiting    : advance last due, advance next due, output
//   backlog limiting       : elapsed, 16 shift-add steps for
//                            interval*max_backlog, compare, two updates, output
// check.ready is high only while the sequencer is idle; one check at a time.
// A finished result sits in an output register, so the next check is taken
// while it waits; if that one finishes too before the receiver takes the
// first, the sequencer holds it until the output register frees up.
// Reset clears the timer state, the run counter and loads the register
// defaults (interval 16666 us, everything else zero).
// ----------------------------------------------------------------------------
module fixed_interval_catchup_timer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    fict_check_if.sink                       check,
    fict_result_if.source                    result,
    input  logic                             cfg_we,
    input  fict_pkg::cfg_idx_t               cfg_index,
    input  logic [fict_pkg::CFG_W-1:0]       cfg_data
);
    import fict_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_REST = 4'd1;
    localparam logic [3:0] ST_ELAP = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_BASE = 4'd5;
    localparam logic [3:0] ST_NEXT = 4'd6;
    localparam logic [3:0] ST_ADV1 = 4'd7;
    localparam logic [3:0] ST_ADV2 = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam int BIT_W = $clog2(BKL_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BKL_W - 1);

    logic [IVL_W-1:0]  interval_reg;
    logic [RUN_W-1:0]  max_run_reg;
    logic              limit_bkl_reg;
    logic [BKL_W-1:0]  max_bkl_reg;

    logic [3:0]        state_reg, state_next;
    time_t             now_reg, now_next;
    time_t             last_reg, last_next;
    time_t             next_reg, next_next;
    time_t             elapsed_reg, elapsed_next;
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic [SPAN_W-1:0] acc_reg, acc_next;
    logic [SPAN_W-1:0] mcand_reg, mcand_next;
    logic [BKL_W-1:0]  mplier_reg, mplier_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              fire_reg, fire_next;
    logic              clamp_reg, clamp_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_fire_reg, out_fire_next;
    time_t             out_due_reg, out_due_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic              accept;
    logic              rest;
    logic              load_out;
    time_t             sum63;

    fict_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign accept   = check.valid & check.ready;
    assign rest     = (max_run_reg != '0) && (cnt_reg == max_run_reg);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
    assign sum63    = alu_rsp.sum[TIME_W-1:0];

    assign check.ready        = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.fire        = out_fire_reg;
    assign result.next_due_us = out_due_reg;

    always_comb
    begin
        alu_req.a   = {1'b0, now_reg};
        alu_req.b   = {{(ALU_W-IVL_W){1'b0}}, interval_reg};
        alu_req.sub = 1'b0;
        case (state_reg)
            ST_ELAP:
            begin
                alu_req.b   = {1'b0, last_reg};
                alu_req.sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_req.a = {{(ALU_W-SPAN_W){1'b0}}, acc_reg};
                alu_req.b = mplier_reg[0] ? {{(ALU_W-SPAN_W){1'b0}}, mcand_reg} : '0;
            end
            ST_CMP:
            begin
                alu_req.a   = {1'b0, elapsed_reg};
                alu_req.b   = {{(ALU_W-SPAN_W){1'b0}}, acc_reg};
                alu_req.sub = 1'b1;
            end
            ST_BASE:
            begin
                alu_req.b   = {{(ALU_W-SPAN_W){1'b0}}, acc_reg};
                alu_req.sub = 1'b1;
            end
            ST_NEXT, ST_ADV1:
            begin
                alu_req.a = {1'b0, last_reg};
            end
            ST_ADV2:
            begin
                alu_req.a = {1'b0, next_reg};
            end
            default:
            begin
                alu_req.a = {1'b0, now_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        next_next      = next_reg;
        elapsed_next   = elapsed_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        bit_next       = bit_reg;
        fire_next      = fire_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg;
        out_fire_next  = out_fire_reg;
        out_due_next   = out_due_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next = check.now_us;
                    if (rest)
                    begin
                        cnt_next   = '0;
                        fire_next  = 1'b0;
                        state_next = ST_REST;
                    end
                    else
                    begin
                        cnt_next    = cnt_reg + 1'b1;
                        fire_next   = 1'b1;
                        acc_next    = '0;
                        mcand_next  = {{(SPAN_W-IVL_W){1'b0}}, interval_reg};
                        mplier_next = max_bkl_reg;
                        bit_next    = '0;
                        state_next  = limit_bkl_reg ? ST_ELAP : ST_ADV1;
                    end
                end
            end
            ST_REST:
            begin
                next_next  = sum63;
                state_next = ST_OUT;
            end
            ST_ELAP:
            begin
                elapsed_next = alu_rsp.borrow ? '0 : sum63;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next    = alu_rsp.sum[SPAN_W-1:0];
                mcand_next  = {mcand_reg[SPAN_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[BKL_W-1:1]};
                bit_next    = bit_reg + 1'b1;
                if (bit_reg == BIT_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                clamp_next = ~alu_rsp.borrow;
                state_next = alu_rsp.borrow ? ST_ADV1 : ST_BASE;
            end
            ST_BASE:
            begin
                last_next  = alu_rsp.borrow ? '0 : sum63;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                next_next  = sum63;
                state_next = ST_OUT;
            end
            ST_ADV1:
            begin
                last_next  = sum63;
                state_next = ST_ADV2;
            end
            ST_ADV2:
            begin
                next_next  = sum63;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_fire_next  = fire_reg;
                    out_due_next   = next_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RST;
            max_run_reg   <= '0;
            limit_bkl_reg <= 1'b0;
            max_bkl_reg   <= '0;
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            next_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INTERVAL:  interval_reg  <= cfg_data[IVL_W-1:0];
                    REG_MAX_RUN:   max_run_reg   <= cfg_data[RUN_W-1:0];
                    REG_LIMIT_BKL: limit_bkl_reg <= cfg_data[0];
                    REG_MAX_BKL:   max_bkl_reg   <= cfg_data[BKL_W-1:0];
                    default:       max_bkl_reg   <= max_bkl_reg;
                endcase
            end
            state_reg     <= state_next;
            last_reg      <= last_next;
            next_reg      <= next_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        bit_reg      <= bit_next;
        fire_reg     <= fire_next;
        clamp_reg    <= clamp_next;
        out_fire_reg <= out_fire_next;
        out_due_reg  <= out_due_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer idle right after a check was accepted");

    a_rest_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rest |=> cnt_reg == '0 && state_reg == ST_REST)
        else $error("forced rest did not clear the run counter");

    a_mul_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL && bit_reg != BIT_LAST |=> state_reg == ST_MUL)
        else $error("shift-add left before all multiplier bits");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output step");

    a_clamp_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BASE |-> clamp_reg && limit_bkl_reg)
        else $error("rebase taken without clamping");
`endif

endmodule
